// ===== src/serial_frame_deframer_core_macros.svh =====
// Assertion macros used by the checker of the frame deframer.
// Depends on nothing; included by the checker module.
`ifndef SERIAL_FRAME_DEFRAMER_CORE_MACROS_SVH
`define SERIAL_FRAME_DEFRAMER_CORE_MACROS_SVH

// Checks a property at each rising clock edge while reset is not asserted.
`define SFD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checks a property at each rising clock edge, reset included.
`define SFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/sfd_pkg.sv =====
// Shared types and constants of the serial frame deframer.
// Depends on nothing; imported by every module of the block.
package sfd_pkg;

    localparam logic [7:0] SOF_BYTE     = 8'h7B;
    localparam logic [7:0] EOF_BYTE     = 8'h7D;
    localparam logic [7:0] SUM_TARGET   = 8'hFF;
    localparam logic [7:0] LEN_OVERHEAD = 8'd4;
    localparam logic [7:0] MIN_LEN      = 8'd5;

    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_DATA = 3'd2,
        PH_CSUM = 3'd3,
        PH_END  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        EV_DATA = 2'd0,
        EV_GOOD = 2'd1,
        EV_ERR  = 2'd2
    } event_t;

    typedef enum logic [2:0] {
        ERR_START   = 3'd0,
        ERR_LEN     = 3'd1,
        ERR_CSUM    = 3'd2,
        ERR_END     = 3'd3,
        ERR_TIMEOUT = 3'd4
    } err_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        event_t     event_res;
        logic [7:0] payload_byte;
        logic [7:0] payload_count;
        err_t       error_code;
    } res_t;

endpackage

// ===== src/serial_frame_deframer_core.sv =====
// Serial frame deframer: hunts for length-prefixed frames with a sum checksum.
// Depends on sfd_pkg, sfd_in_reg and sfd_proc.
//
// Input channel (s_): one word per item, either a received byte (s_kind 0)
// or an idle timeout event (s_kind 1). Result channel (m_): at most one word
// per input word, carrying a payload byte, a good-frame report with its
// payload count, or a frame error with its code.
// A frame is '{', a length byte L (at least 5), L-4 payload bytes, a checksum
// byte that makes the sum of L, the payload and itself equal 0xFF, and '}'.
// A result passes through the input register and then the output register
// before it appears on m_valid.
// Throughput: one input word per cycle while results are taken, set by the single
// register-to-register pass through the frame state machine.
// The input register is refilled in the same cycle it is drained, and the
// output register is reloaded in the cycle it is read. When the receiver
// stalls with a result held, one more word waits in the input register and
// s_ready then drops; words that yield no result still pass.
// Reset (aresetn low, synchronous) empties both registers and returns the
// receiver to hunting for a start byte with counts and sum cleared.
module serial_frame_deframer_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_kind,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_event_res,
    output logic [7:0] m_payload_byte,
    output logic [7:0] m_payload_count,
    output logic [2:0] m_error_code
);
    import sfd_pkg::*;

    item_t s_item;
    item_t item;
    logic  item_valid;
    logic  take;
    logic  res_valid;
    res_t  res;
    logic  m_valid_reg;
    logic  m_valid_next;
    res_t  m_res_reg;

    assign s_item.kind    = s_kind;
    assign s_item.rx_byte = s_rx_byte;

    assign take = item_valid && (!res_valid || !m_valid_reg || m_ready);

    sfd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_item     (s_item),
        .s_ready    (s_ready),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    sfd_proc u_proc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item      (item),
        .take      (take),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        if (take && res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_event_res     = m_res_reg.event_res;
    assign m_payload_byte  = m_res_reg.payload_byte;
    assign m_payload_count = m_res_reg.payload_count;
    assign m_error_code    = m_res_reg.error_code;

endmodule

// ===== src/sfd_in_reg.sv =====
// Input register of the deframer: holds one accepted word until the frame logic takes it.
// Depends on sfd_pkg.
module sfd_in_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  sfd_pkg::item_t s_item,
    output logic          s_ready,
    input  logic          take,
    output logic          item_valid,
    output sfd_pkg::item_t item
);
    import sfd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== src/sfd_proc.sv =====
// Frame state machine with length counter and running checksum.
// Depends on sfd_pkg; updates its state on each word taken from the input register.
module sfd_proc (
    input  logic           aclk,
    input  logic           aresetn,
    input  sfd_pkg::item_t item,
    input  logic           take,
    output logic           res_valid,
    output sfd_pkg::res_t  res
);
    import sfd_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] expected_reg;
    logic [7:0] expected_next;
    logic [7:0] received_reg;
    logic [7:0] received_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] c;
    logic [7:0] sum_plus;
    logic [7:0] received_plus;

    assign c             = item.rx_byte;
    assign sum_plus      = sum_reg + c;
    assign received_plus = received_reg + 8'd1;

    always_comb begin
        phase_next    = phase_reg;
        expected_next = expected_reg;
        received_next = received_reg;
        sum_next      = sum_reg;
        if (item.kind == KIND_TIMEOUT) begin
            phase_next    = PH_HUNT;
            expected_next = 8'd0;
            received_next = 8'd0;
            sum_next      = 8'd0;
        end else begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (c == SOF_BYTE) begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (c < MIN_LEN) begin
                        phase_next    = PH_HUNT;
                        expected_next = 8'd0;
                        received_next = 8'd0;
                        sum_next      = 8'd0;
                    end else begin
                        phase_next    = PH_DATA;
                        expected_next = c - LEN_OVERHEAD;
                        received_next = 8'd0;
                        sum_next      = c;
                    end
                end
                PH_DATA: begin
                    sum_next      = sum_plus;
                    received_next = received_plus;
                    if (received_plus >= expected_reg) begin
                        phase_next = PH_CSUM;
                    end
                end
                PH_CSUM: begin
                    if (sum_plus == SUM_TARGET) begin
                        phase_next = PH_END;
                    end else begin
                        phase_next    = PH_HUNT;
                        expected_next = 8'd0;
                        received_next = 8'd0;
                        sum_next      = 8'd0;
                    end
                end
                default: begin
                    phase_next    = PH_HUNT;
                    expected_next = 8'd0;
                    received_next = 8'd0;
                    sum_next      = 8'd0;
                end
            endcase
        end
    end

    always_comb begin
        res_valid         = 1'b0;
        res.event_res     = EV_DATA;
        res.payload_byte  = 8'd0;
        res.payload_count = 8'd0;
        res.error_code    = ERR_START;
        if (item.kind == KIND_TIMEOUT) begin
            if (phase_reg != PH_HUNT) begin
                res_valid      = 1'b1;
                res.event_res  = EV_ERR;
                res.error_code = ERR_TIMEOUT;
            end
        end else begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (c != SOF_BYTE) begin
                        res_valid      = 1'b1;
                        res.event_res  = EV_ERR;
                        res.error_code = ERR_START;
                    end
                end
                PH_LEN: begin
                    if (c < MIN_LEN) begin
                        res_valid      = 1'b1;
                        res.event_res  = EV_ERR;
                        res.error_code = ERR_LEN;
                    end
                end
                PH_DATA: begin
                    res_valid        = 1'b1;
                    res.event_res    = EV_DATA;
                    res.payload_byte = c;
                end
                PH_CSUM: begin
                    if (sum_plus != SUM_TARGET) begin
                        res_valid      = 1'b1;
                        res.event_res  = EV_ERR;
                        res.error_code = ERR_CSUM;
                    end
                end
                default: begin
                    res_valid = 1'b1;
                    if (c == EOF_BYTE) begin
                        res.event_res     = EV_GOOD;
                        res.payload_count = expected_reg;
                    end else begin
                        res.event_res  = EV_ERR;
                        res.error_code = ERR_END;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HUNT;
            expected_reg <= 8'd0;
            received_reg <= 8'd0;
            sum_reg      <= 8'd0;
        end else if (take) begin
            phase_reg    <= phase_next;
            expected_reg <= expected_next;
            received_reg <= received_next;
            sum_reg      <= sum_next;
        end
    end

endmodule

// ===== src/sfd_checker.sv =====
// Port-level checker of the serial frame deframer, bound to the top level.
// Depends on sfd_pkg and serial_frame_deframer_core_macros.svh.
`include "serial_frame_deframer_core_macros.svh"

module sfd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_event_res,
    input logic [7:0] m_payload_byte,
    input logic [7:0] m_payload_count,
    input logic [2:0] m_error_code
);
    import sfd_pkg::*;

    `SFD_ASSERT(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_payload_byte), "result word changed while stalled")
    `SFD_ASSERT(a_event, aclk, aresetn, m_valid |-> m_event_res != 2'd3, "undefined event code")
    `SFD_ASSERT(a_count, aclk, aresetn, m_valid && m_event_res == EV_GOOD |-> m_payload_count != 8'd0 && m_payload_count <= 8'd251, "good frame count out of range")
    `SFD_ASSERT(a_err, aclk, aresetn, m_valid && m_event_res == EV_ERR |-> m_error_code <= ERR_TIMEOUT, "undefined error code")
    `SFD_ASSERT_ALWAYS(a_reset, aclk, !aresetn |=> !m_valid, "result word present after reset")

endmodule

bind serial_frame_deframer_core sfd_checker u_sfd_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for serial_frame_deframer_core: a directed table of frames and faults, then
// random frames, every result word checked against a behavioral model or the table's expected word.
// Depends on sfd_pkg and the RTL of serial_frame_deframer_core.
module tb;
    import sfd_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_WORDS   = 500;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RESET_CYCLES   = 9;

    typedef struct {
        item_t w;
        logic  known;
        logic  has;
        res_t  r;
    } plan_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_kind = KIND_BYTE;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_event_res;
    logic [7:0] m_payload_byte;
    logic [7:0] m_payload_count;
    logic [2:0] m_error_code;

    logic       cur_known = 1'b0;
    logic       cur_has = 1'b0;
    res_t       cur_res = '0;

    phase_t     fr_phase = PH_HUNT;
    logic [7:0] fr_expect = 8'h00;
    logic [7:0] fr_taken = 8'h00;
    logic [7:0] fr_sum = 8'h00;

    res_t       expected_q[$];
    plan_row_t  plan[$];
    int         errors_seen = 0;
    int         quiet_cycles = 0;
    bit         tx_idle = 1'b1;
    bit         rx_idle = 1'b1;

    serial_frame_deframer_core uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .m_payload_byte  (m_payload_byte),
        .m_payload_count (m_payload_count),
        .m_error_code    (m_error_code)
    );

    always begin
        #2;
        aclk = ~aclk;
    end

    function automatic item_t word_of(input logic k, input logic [7:0] b);
        item_t w;
        w.kind    = k;
        w.rx_byte = b;
        return w;
    endfunction

    function automatic void frame_clear();
        fr_phase  = PH_HUNT;
        fr_expect = 8'h00;
        fr_taken  = 8'h00;
        fr_sum    = 8'h00;
    endfunction

    function automatic void deframe_step(input logic k, input logic [7:0] b,
                                         output logic has, output res_t r);
        logic [7:0] cnt;
        logic [7:0] total;
        has = 1'b0;
        r = '0;
        if (k == KIND_TIMEOUT) begin
            if (fr_phase != PH_HUNT) begin
                frame_clear();
                has = 1'b1;
                r.event_res = EV_ERR;
                r.error_code = ERR_TIMEOUT;
            end
        end else begin
            case (fr_phase)
                PH_HUNT: begin
                    if (b == SOF_BYTE) begin
                        fr_phase = PH_LEN;
                    end else begin
                        has = 1'b1;
                        r.event_res = EV_ERR;
                        r.error_code = ERR_START;
                    end
                end
                PH_LEN: begin
                    if (b < MIN_LEN) begin
                        frame_clear();
                        has = 1'b1;
                        r.event_res = EV_ERR;
                        r.error_code = ERR_LEN;
                    end else begin
                        fr_expect = b - LEN_OVERHEAD;
                        fr_taken  = 8'h00;
                        fr_sum    = b;
                        fr_phase  = PH_DATA;
                    end
                end
                PH_DATA: begin
                    fr_sum   = fr_sum + b;
                    fr_taken = fr_taken + 8'd1;
                    if (fr_taken >= fr_expect) begin
                        fr_phase = PH_CSUM;
                    end
                    has = 1'b1;
                    r.event_res = EV_DATA;
                    r.payload_byte = b;
                end
                PH_CSUM: begin
                    total = fr_sum + b;
                    if (total == SUM_TARGET) begin
                        fr_phase = PH_END;
                    end else begin
                        frame_clear();
                        has = 1'b1;
                        r.event_res = EV_ERR;
                        r.error_code = ERR_CSUM;
                    end
                end
                default: begin
                    cnt = fr_expect;
                    frame_clear();
                    has = 1'b1;
                    if (b == EOF_BYTE) begin
                        r.event_res = EV_GOOD;
                        r.payload_count = cnt;
                    end else begin
                        r.event_res = EV_ERR;
                        r.error_code = ERR_END;
                    end
                end
            endcase
        end
    endfunction

    task automatic plan_word(input logic k, input logic [7:0] b);
        plan_row_t row;
        row.w = word_of(k, b);
        row.known = 1'b0;
        row.has = 1'b0;
        row.r = '0;
        plan.push_back(row);
    endtask

    task automatic plan_known(input logic k, input logic [7:0] b, input logic has,
                              input event_t ev, input logic [7:0] cnt, input err_t err);
        plan_row_t row;
        row.w = word_of(k, b);
        row.known = 1'b1;
        row.has = has;
        row.r = '0;
        row.r.event_res = ev;
        row.r.payload_count = cnt;
        row.r.error_code = err;
        plan.push_back(row);
    endtask

    task automatic send_word(input item_t w, input logic known, input logic has,
                             input res_t r);
        int gap;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_kind    <= w.kind;
        s_rx_byte <= w.rx_byte;
        cur_known <= known;
        cur_has   <= has;
        cur_res   <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic random_frame(input bit force_max, inout int words);
        item_t      seq[$];
        int         len;
        int         flaw;
        int         pos;
        logic [7:0] sum;
        logic [7:0] b;
        res_t       none;
        none = '0;
        flaw = force_max ? 0 : $urandom_range(0, 9);
        if (flaw == 9) begin
            case ($urandom_range(0, 2))
                0: begin
                    // A timeout while hunting is ignored and does not count as work.
                    send_word(word_of(KIND_TIMEOUT, 8'($urandom_range(0, 255))), 1'b0, 1'b0,
                              none);
                end
                1: begin
                    do b = 8'($urandom_range(0, 255)); while (b == SOF_BYTE);
                    seq.push_back(word_of(KIND_BYTE, b));
                end
                default: begin
                    seq.push_back(word_of(KIND_BYTE, SOF_BYTE));
                    seq.push_back(word_of(KIND_BYTE, 8'($urandom_range(0, 4))));
                end
            endcase
        end else begin
            if (force_max || $urandom_range(0, 49) == 0) begin
                len = 255;
            end else if ($urandom_range(0, 7) == 0) begin
                len = $urandom_range(5, 64);
            end else begin
                len = $urandom_range(5, 12);
            end
            sum = len[7:0];
            seq.push_back(word_of(KIND_BYTE, SOF_BYTE));
            seq.push_back(word_of(KIND_BYTE, len[7:0]));
            for (int i = 0; i < len - 4; i++) begin
                b = 8'($urandom_range(0, 255));
                sum = sum + b;
                seq.push_back(word_of(KIND_BYTE, b));
            end
            seq.push_back(word_of(KIND_BYTE, SUM_TARGET - sum));
            seq.push_back(word_of(KIND_BYTE, EOF_BYTE));
            if (flaw == 6) begin
                seq[len - 2].rx_byte = seq[len - 2].rx_byte ^ 8'($urandom_range(1, 255));
            end else if (flaw == 7) begin
                do b = 8'($urandom_range(0, 255)); while (b == EOF_BYTE);
                seq[len - 1].rx_byte = b;
            end else if (flaw == 8) begin
                pos = $urandom_range(1, len);
                while (seq.size() > pos) void'(seq.pop_back());
                seq.push_back(word_of(KIND_TIMEOUT, 8'($urandom_range(0, 255))));
            end
        end
        foreach (seq[i]) begin
            send_word(seq[i], 1'b0, 1'b0, none);
        end
        words += seq.size();
    endtask

    always @(posedge aclk) begin : scoreboard
        res_t want;
        res_t pred;
        logic has;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result word with none expected: event_res %0d", m_event_res);
                    errors_seen++;
                end else begin
                    want = expected_q.pop_front();
                    if (m_event_res !== want.event_res) begin
                        $error("event_res: expected %0d, got %0d", want.event_res, m_event_res);
                        errors_seen++;
                    end
                    if (m_payload_byte !== want.payload_byte) begin
                        $error("payload_byte: expected %0d, got %0d",
                               want.payload_byte, m_payload_byte);
                        errors_seen++;
                    end
                    if (m_payload_count !== want.payload_count) begin
                        $error("payload_count: expected %0d, got %0d",
                               want.payload_count, m_payload_count);
                        errors_seen++;
                    end
                    if (m_error_code !== want.error_code) begin
                        $error("error_code: expected %0d, got %0d",
                               want.error_code, m_error_code);
                        errors_seen++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                deframe_step(s_kind, s_rx_byte, has, pred);
                if (cur_known) begin
                    has = cur_has;
                    pred = cur_res;
                end
                if (has) begin
                    expected_q.push_back(pred);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : result_side
        int gap;
        int taken;
        taken = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken % 40 == 0) begin
                rx_idle = ($urandom_range(0, 2) != 0);
            end
            gap = rx_idle ? $urandom_range(0, 4) : 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            taken++;
        end
    end

    initial begin : byte_side
        int words;
        int frames;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        plan_known(KIND_TIMEOUT, 8'h00, 1'b0, EV_DATA, 8'd0, ERR_START);
        plan_known(KIND_BYTE, 8'h00, 1'b1, EV_ERR, 8'd0, ERR_START);
        plan_known(KIND_BYTE, 8'hFF, 1'b1, EV_ERR, 8'd0, ERR_START);
        plan_word(KIND_BYTE, SOF_BYTE);
        plan_known(KIND_BYTE, 8'h04, 1'b1, EV_ERR, 8'd0, ERR_LEN);
        plan_word(KIND_BYTE, SOF_BYTE);
        plan_known(KIND_BYTE, 8'h00, 1'b1, EV_ERR, 8'd0, ERR_LEN);
        plan_word(KIND_BYTE, SOF_BYTE);
        plan_known(KIND_TIMEOUT, 8'hFF, 1'b1, EV_ERR, 8'd0, ERR_TIMEOUT);
        plan_word(KIND_BYTE, SOF_BYTE);
        plan_word(KIND_BYTE, 8'h05);
        plan_word(KIND_BYTE, 8'hAA);
        plan_word(KIND_BYTE, 8'h50);
        plan_known(KIND_BYTE, EOF_BYTE, 1'b1, EV_GOOD, 8'd1, ERR_START);
        plan_word(KIND_BYTE, SOF_BYTE);
        plan_word(KIND_BYTE, 8'h05);
        plan_word(KIND_BYTE, 8'h00);
        plan_known(KIND_BYTE, 8'h00, 1'b1, EV_ERR, 8'd0, ERR_CSUM);
        plan_word(KIND_BYTE, SOF_BYTE);
        plan_word(KIND_BYTE, 8'h05);
        plan_word(KIND_BYTE, 8'h55);
        plan_word(KIND_BYTE, 8'hA5);
        plan_known(KIND_BYTE, 8'h00, 1'b1, EV_ERR, 8'd0, ERR_END);
        plan_word(KIND_BYTE, SOF_BYTE);
        plan_word(KIND_BYTE, 8'h06);
        plan_word(KIND_BYTE, 8'hFF);
        plan_known(KIND_TIMEOUT, 8'h00, 1'b1, EV_ERR, 8'd0, ERR_TIMEOUT);
        foreach (plan[i]) begin
            send_word(plan[i].w, plan[i].known, plan[i].has, plan[i].r);
        end

        words = 0;
        frames = 0;
        while (words < RANDOM_WORDS) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            random_frame(frames == 2, words);
            frames++;
            if (frames % 10 == 0) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (expected_q.size() != 0);
            end
        end
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors_seen == 0 && expected_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
